FILE: hw/rtl/iawm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iawm_pkg: shared types and constants of the window mapper
// Entry count, command and kind codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package iawm_pkg;

  localparam int MapperCount = 8;
  localparam int IdxW        = (MapperCount > 1) ? $clog2(MapperCount) : 1;
  localparam logic [7:0] VersionByte = 8'd1;

  // operations
  localparam logic [1:0] OP_IO_RD  = 2'd0;
  localparam logic [1:0] OP_IO_WR  = 2'd1;
  localparam logic [1:0] OP_MEM_RD = 2'd2;
  localparam logic [1:0] OP_MEM_WR = 2'd3;

  // io offsets
  localparam logic [2:0] OFF_VERSION = 3'd0;
  localparam logic [2:0] OFF_CMD     = 3'd1;
  localparam logic [2:0] OFF_DATA    = 3'd2;

  // command codes
  localparam logic [7:0] CMD_ENABLE    = 8'd0;
  localparam logic [7:0] CMD_CUR_ENTRY = 8'd1;
  localparam logic [7:0] CMD_BASE      = 8'd2;
  localparam logic [7:0] CMD_LENGTH    = 8'd3;
  localparam logic [7:0] CMD_KIND      = 8'd4;
  localparam logic [7:0] CMD_FLAGS     = 8'd5;
  localparam logic [7:0] CMD_CTRL      = 8'd6;
  localparam logic [7:0] CMD_CTRL_CODE = 8'd7;
  localparam logic [7:0] CMD_CTRL_DATA = 8'd8;
  localparam logic [7:0] CMD_SHORTCUT  = 8'd9;

  localparam logic [7:0] KIND_MAX = 8'd7;
  localparam logic [3:0] KIND_NONE = 4'd0;

  localparam logic [1:0] ROUTE_NONE  = 2'd0;
  localparam logic [1:0] ROUTE_READ  = 2'd1;
  localparam logic [1:0] ROUTE_WRITE = 2'd2;

  localparam logic [1:0] CREQ_NONE  = 2'd0;
  localparam logic [1:0] CREQ_WRITE = 2'd1;
  localparam logic [1:0] CREQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  io_offset;
    logic [31:0] mem_addr;
    logic [7:0]  wr_data;
  } item_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic [1:0] route;
    logic [2:0] entry_index;
    logic [1:0] ctrl_req;
    logic [7:0] ctrl_code;
    logic [7:0] ctrl_arg;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic            load;     // capture item
    logic            io_exec;  // perform io access
    logic            scan_clr; // start a scan
    logic            scan_step;// test entry scan_idx
    logic [IdxW-1:0] scan_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mem;
    logic hit;     // current scan entry claims the access
  } dp_sts_t;

endpackage

FILE: hw/rtl/indirect_address_window_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_address_window_mapper_top: programmable memory window router
// Byte-wide io window programs entries; memory accesses are routed by scan.
// ----------------------------------------------------------------------------
// One item at a time. An io access offers its result after the execute step;
// a memory access offers it after the execute step and a scan of k entries, where k
// (1..8) is the number of entries tested, one per cycle by the shared window
// comparator, stopping at the first entry that claims the access. The next
// item is taken only once the result has been taken and the sequencer is idle.
module indirect_address_window_mapper_top
  import iawm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // op[1:0], io_offset[4:2], mem_addr[36:5], wr_data[44:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // rd_data, route, entry_index, ctrl_req, ctrl_code, ctrl_arg
);

  item_t   it;
  result_t rs;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign it.op        = in_tdata[1:0];
  assign it.io_offset = in_tdata[4:2];
  assign it.mem_addr  = in_tdata[36:5];
  assign it.wr_data   = in_tdata[44:37];
  assign out_tdata = {1'b0, rs.ctrl_arg, rs.ctrl_code, rs.ctrl_req,
                      rs.entry_index, rs.route, rs.rd_data};

  iawm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .sts, .cmd
  );

  iawm_datapath u_dp (
    .clk, .rst_n, .item_in(it), .cmd, .sts, .res(rs)
  );

endmodule

FILE: hw/rtl/iawm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iawm_datapath: entry table, io window registers and window compare
// Executes io accesses in one step and tests one entry per scan step.
// ----------------------------------------------------------------------------
module iawm_datapath
  import iawm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   item_in,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output result_t res
);

  logic [31:0] base_r [MapperCount];
  logic [31:0] len_r  [MapperCount];
  logic [7:0]  flags_r[MapperCount];
  logic [3:0]  kind_r [MapperCount];
  logic [7:0]  cmd_sel_r, code_r, cdata_r;
  logic [31:0] wide_r;
  logic [IdxW-1:0] cur_r;
  logic        gen_r, short_r;
  item_t       it_r;
  result_t     res_r;

  logic [IdxW-1:0] si;
  logic [32:0] win_end;
  logic        in_win;
  logic [31:0] len_eff;

  // window compare for the entry under scan
  assign si      = cmd.scan_idx;
  assign win_end = {1'b0, base_r[si]} + {1'b0, len_r[si]} - 33'd1;
  assign in_win  = (len_r[si] == 32'd0) ? (base_r[si] == 32'd0) :
                   (!win_end[32] && it_r.mem_addr >= base_r[si] &&
                    it_r.mem_addr <= win_end[31:0]) ||
                   (win_end[32] && 1'b0);
  assign sts.is_mem = it_r.op[1];
  assign sts.hit = in_win && kind_r[si] != KIND_NONE &&
                   ((it_r.op == OP_MEM_RD && flags_r[si][0]) || flags_r[si][1]);
  assign res = res_r;
  assign len_eff = (wide_r == 32'd0) ? 32'd1 : wide_r;

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MapperCount; i++) begin
        base_r[i] <= '0; len_r[i] <= '0; flags_r[i] <= '0; kind_r[i] <= '0;
      end
      cmd_sel_r <= '0; code_r <= '0; cdata_r <= '0; wide_r <= '0;
      cur_r <= '0; gen_r <= 1'b0; short_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        it_r  <= item_in;
        res_r <= '0;
      end
      if (cmd.scan_step && sts.hit && res_r.route == ROUTE_NONE) begin
        res_r.route <= (it_r.op == OP_MEM_RD && flags_r[si][0]) ?
                       ROUTE_READ : ROUTE_WRITE;
        res_r.entry_index <= 3'(si);
      end
      if (cmd.io_exec) begin
        if (it_r.op == OP_IO_RD) begin
          if (it_r.io_offset == OFF_VERSION) res_r.rd_data <= VersionByte;
          else if (it_r.io_offset[2])
            res_r.rd_data <= wide_r[8*it_r.io_offset[1:0] +: 8];
          else if (it_r.io_offset == OFF_CMD) begin
            unique case (cmd_sel_r)
              CMD_ENABLE:    res_r.rd_data <= {7'd0, gen_r};
              CMD_CUR_ENTRY: res_r.rd_data <= 8'(cur_r);
              CMD_BASE: begin
                wide_r        <= base_r[cur_r];
                res_r.rd_data <= 8'hFF;
              end
              CMD_LENGTH: begin
                wide_r        <= len_r[cur_r];
                res_r.rd_data <= 8'hFF;
              end
              CMD_KIND:      res_r.rd_data <= {4'd0, kind_r[cur_r]};
              CMD_FLAGS:     res_r.rd_data <= flags_r[cur_r];
              CMD_CTRL: begin
                res_r.rd_data <= 8'hFF;
                if (kind_r[cur_r] != KIND_NONE) begin
                  res_r.ctrl_req  <= CREQ_READ;
                  res_r.ctrl_code <= code_r;
                  res_r.ctrl_arg  <= cdata_r;
                end
              end
              CMD_CTRL_CODE: res_r.rd_data <= code_r;
              CMD_CTRL_DATA: res_r.rd_data <= cdata_r;
              CMD_SHORTCUT:  res_r.rd_data <= {7'd0, short_r};
              default:       res_r.rd_data <= 8'hFF;
            endcase
          end else res_r.rd_data <= 8'hFF;
        end else if (it_r.op == OP_IO_WR) begin
          if (it_r.io_offset == OFF_CMD) cmd_sel_r <= it_r.wr_data;
          else if (it_r.io_offset[2])
            wide_r[8*it_r.io_offset[1:0] +: 8] <= it_r.wr_data;
          else if (it_r.io_offset == OFF_DATA) begin
            unique case (cmd_sel_r)
              CMD_ENABLE:    gen_r <= it_r.wr_data != 8'd0;
              CMD_CUR_ENTRY: cur_r <= (it_r.wr_data > 8'(MapperCount - 1)) ?
                                      IdxW'(MapperCount - 1) : IdxW'(it_r.wr_data);
              CMD_BASE:      base_r[cur_r] <= wide_r;
              CMD_LENGTH:    len_r[cur_r] <= len_eff;
              CMD_KIND:      kind_r[cur_r] <= (it_r.wr_data <= KIND_MAX) ?
                                              it_r.wr_data[3:0] : KIND_NONE;
              CMD_FLAGS:     flags_r[cur_r] <= it_r.wr_data;
              CMD_CTRL: if (kind_r[cur_r] != KIND_NONE) begin
                res_r.ctrl_req  <= CREQ_WRITE;
                res_r.ctrl_code <= code_r;
                res_r.ctrl_arg  <= it_r.wr_data;
              end
              CMD_CTRL_CODE: code_r <= it_r.wr_data;
              CMD_CTRL_DATA: cdata_r <= it_r.wr_data;
              CMD_SHORTCUT:  short_r <= it_r.wr_data != 8'd0;
              default: ;
            endcase
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/iawm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iawm_ctrl: sequencer of the window mapper
// Accepts an item, runs an io step or an entry scan, then offers the result.
// ----------------------------------------------------------------------------
module iawm_ctrl
  import iawm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;
  state_t state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic last;

  assign last      = idx_r == IdxW'(MapperCount - 1);
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_DONE;

  // command decode
  always_comb begin
    cmd = '0;
    cmd.load      = in_valid && in_ready;
    cmd.io_exec   = state_r == S_EXEC && !sts.is_mem;
    cmd.scan_step = state_r == S_SCAN;
    cmd.scan_clr  = state_r == S_EXEC;
    cmd.scan_idx  = idx_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        idx_nxt   = '0;
        state_nxt = sts.is_mem ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (sts.hit || last) state_nxt = S_DONE;
        else idx_nxt = idx_r + 1'b1;
      end
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && last) |=> state_r == S_DONE)
    else $error("scan ran past last entry");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule
